[sv/rc4_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 package
// Shared widths, configuration register indexes, sequencer states and the
// key information passed from the key register file to the core.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int DATA_W        = 8;
    localparam int S_DEPTH       = 256;
    localparam int S_ADDR_W      = $clog2(S_DEPTH);

    localparam int MAX_KEY_BYTES = 32;
    localparam int KEY_REGS      = 4;
    localparam int KEY_REG_W     = 64;
    localparam int KEY_TOTAL     = KEY_REGS * (KEY_REG_W / DATA_W);
    localparam int KEY_CAP       = (MAX_KEY_BYTES < KEY_TOTAL) ? MAX_KEY_BYTES : KEY_TOTAL;
    localparam int KEY_IDX_W     = $clog2(KEY_TOTAL);
    localparam int KEY_SEL_W     = $clog2(KEY_REGS);
    localparam int KEY_BYTE_SEL_W = $clog2(KEY_REG_W / DATA_W);
    localparam int KEY_LEN_W     = 6;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = KEY_REG_W;

    // register indexes: the key words occupy indexes 0 to KEY_REGS-1
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_FIRST = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN   = CFG_IDX_W'(KEY_REGS);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_INIT   = 11'b000_0000_0010,
        ST_K_RD_N = 11'b000_0000_0100,
        ST_K_RD_J = 11'b000_0000_1000,
        ST_K_WR_N = 11'b000_0001_0000,
        ST_K_WR_J = 11'b000_0010_0000,
        ST_P_RD_I = 11'b000_0100_0000,
        ST_P_RD_J = 11'b000_1000_0000,
        ST_P_WR_I = 11'b001_0000_0000,
        ST_P_WR_J = 11'b010_0000_0000,
        ST_P_HOLD = 11'b100_0000_0000
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0]    key_byte;
        logic [KEY_IDX_W-1:0] len_m1;
    } t_key_info;

endpackage

[sv/rc4_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/rc4_key_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 key register file
// Holds the key words and key length written through the configuration
// port, selects the key byte for the scheduling pass and saturates the length.
// ----------------------------------------------------------------------------
module rc4_key_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [rc4_pkg::KEY_IDX_W-1:0]      i_key_idx,
    output rc4_pkg::t_key_info                 o_key
);

    logic [rc4_pkg::KEY_REG_W-1:0] r_key [rc4_pkg::KEY_REGS];
    logic [rc4_pkg::KEY_LEN_W-1:0] r_len;

    logic [rc4_pkg::KEY_SEL_W-1:0]      w_reg_sel;
    logic [rc4_pkg::KEY_BYTE_SEL_W-1:0] w_byte_sel;
    logic [rc4_pkg::KEY_REG_W-1:0]      w_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rc4_pkg::KEY_REGS; k++) begin
                r_key[k] <= '0;
            end
            r_len <= rc4_pkg::KEY_LEN_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == rc4_pkg::CFG_KEY_LEN) begin
                r_len <= i_cfg_data[rc4_pkg::KEY_LEN_W-1:0];
            end else if (i_cfg_index < rc4_pkg::CFG_KEY_LEN &&
                         i_cfg_index >= rc4_pkg::CFG_KEY_FIRST) begin
                r_key[rc4_pkg::KEY_SEL_W'(i_cfg_index - rc4_pkg::CFG_KEY_FIRST)] <=
                    i_cfg_data;
            end
        end
    end

    assign w_reg_sel  = i_key_idx[rc4_pkg::KEY_IDX_W-1:rc4_pkg::KEY_BYTE_SEL_W];
    assign w_byte_sel = i_key_idx[rc4_pkg::KEY_BYTE_SEL_W-1:0];
    assign w_word     = r_key[w_reg_sel];

    always_comb begin
        o_key.key_byte = w_word[w_byte_sel*rc4_pkg::DATA_W +: rc4_pkg::DATA_W];
        // zero length acts as one, anything past the cap saturates
        if (r_len == '0) begin
            o_key.len_m1 = '0;
        end else if (r_len > rc4_pkg::KEY_LEN_W'(rc4_pkg::KEY_CAP)) begin
            o_key.len_m1 = rc4_pkg::KEY_IDX_W'(rc4_pkg::KEY_CAP - 1);
        end else begin
            o_key.len_m1 = rc4_pkg::KEY_IDX_W'(r_len - rc4_pkg::KEY_LEN_W'(1));
        end
    end

endmodule

[sv/rc4_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 core sequencer
// Drives the permutation RAM through key scheduling and the keystream step,
// and holds the output register of the result channel.
// ----------------------------------------------------------------------------
module rc4_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [rc4_pkg::DATA_W-1:0]        i_data_byte,
    input  logic                              i_start_message,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [rc4_pkg::DATA_W-1:0]        o_out_byte,
    output logic [rc4_pkg::KEY_IDX_W-1:0]     o_key_idx,
    input  rc4_pkg::t_key_info                i_key,
    output logic                              o_ram_we,
    output logic [rc4_pkg::S_ADDR_W-1:0]      o_ram_waddr,
    output logic [rc4_pkg::DATA_W-1:0]        o_ram_wdata,
    output logic [rc4_pkg::S_ADDR_W-1:0]      o_ram_raddr,
    input  logic [rc4_pkg::DATA_W-1:0]        i_ram_rdata
);

    rc4_pkg::t_state r_state, n_state;

    logic [rc4_pkg::S_ADDR_W-1:0]  r_i, n_i;
    logic [rc4_pkg::S_ADDR_W-1:0]  r_j, n_j;
    logic [rc4_pkg::S_ADDR_W-1:0]  r_n, n_n;
    logic [rc4_pkg::KEY_IDX_W-1:0] r_kidx, n_kidx;
    logic [rc4_pkg::DATA_W-1:0]    r_sx, n_sx;
    logic [rc4_pkg::DATA_W-1:0]    r_sy, n_sy;
    logic                          r_fwd_i, n_fwd_i;
    logic                          r_fwd_j, n_fwd_j;
    logic [rc4_pkg::DATA_W-1:0]    r_data, n_data;
    logic [rc4_pkg::DATA_W-1:0]    r_res, n_res;
    logic                          r_out_valid, n_out_valid;
    logic [rc4_pkg::DATA_W-1:0]    r_out_byte, n_out_byte;

    logic [rc4_pkg::S_ADDR_W-1:0]  w_sum;
    logic [rc4_pkg::DATA_W-1:0]    w_ks;
    logic [rc4_pkg::DATA_W-1:0]    w_res;
    logic                          w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_sum      = rc4_pkg::S_ADDR_W'(r_sx + i_ram_rdata);
    // the sum was read while S[i] was being written and before S[j] was
    assign w_ks  = r_fwd_i ? r_sy : (r_fwd_j ? r_sx : i_ram_rdata);
    assign w_res = r_data ^ w_ks;

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_n         = r_n;
        n_kidx      = r_kidx;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_fwd_i     = r_fwd_i;
        n_fwd_j     = r_fwd_j;
        n_data      = r_data;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        o_in_ready  = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_n;
        o_ram_wdata = r_n;
        o_ram_raddr = r_n;

        case (r_state)
            rc4_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_data = i_data_byte;
                    if (i_start_message) begin
                        n_n     = '0;
                        n_state = rc4_pkg::ST_INIT;
                    end else begin
                        n_i         = r_i + 1'b1;
                        o_ram_raddr = r_i + 1'b1;
                        n_state     = rc4_pkg::ST_P_RD_J;
                    end
                end
            end
            rc4_pkg::ST_INIT: begin
                // identity fill, one entry a cycle
                o_ram_we = 1'b1;
                n_n      = r_n + 1'b1;
                if (r_n == '1) begin
                    n_j     = '0;
                    n_kidx  = '0;
                    n_state = rc4_pkg::ST_K_RD_N;
                end
            end
            rc4_pkg::ST_K_RD_N: begin
                n_state = rc4_pkg::ST_K_RD_J;
            end
            rc4_pkg::ST_K_RD_J: begin
                n_j         = rc4_pkg::S_ADDR_W'(r_j + i_ram_rdata + i_key.key_byte);
                n_sx        = i_ram_rdata;
                o_ram_raddr = n_j;
                n_state     = rc4_pkg::ST_K_WR_N;
            end
            rc4_pkg::ST_K_WR_N: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = i_ram_rdata;
                n_state     = rc4_pkg::ST_K_WR_J;
            end
            rc4_pkg::ST_K_WR_J: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_j;
                o_ram_wdata = r_sx;
                n_n         = r_n + 1'b1;
                n_kidx      = (r_kidx == i_key.len_m1) ? '0 : r_kidx + 1'b1;
                if (r_n == '1) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = rc4_pkg::ST_P_RD_I;
                end else begin
                    n_state = rc4_pkg::ST_K_RD_N;
                end
            end
            rc4_pkg::ST_P_RD_I: begin
                n_i         = r_i + 1'b1;
                o_ram_raddr = r_i + 1'b1;
                n_state     = rc4_pkg::ST_P_RD_J;
            end
            rc4_pkg::ST_P_RD_J: begin
                n_j         = rc4_pkg::S_ADDR_W'(r_j + i_ram_rdata);
                n_sx        = i_ram_rdata;
                o_ram_raddr = n_j;
                n_state     = rc4_pkg::ST_P_WR_I;
            end
            rc4_pkg::ST_P_WR_I: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_i;
                o_ram_wdata = i_ram_rdata;
                o_ram_raddr = w_sum;
                n_sy        = i_ram_rdata;
                n_fwd_i     = (w_sum == r_i);
                n_fwd_j     = (w_sum == r_j);
                n_state     = rc4_pkg::ST_P_WR_J;
            end
            rc4_pkg::ST_P_WR_J: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_j;
                o_ram_wdata = r_sx;
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = w_res;
                    n_state     = rc4_pkg::ST_IDLE;
                end else begin
                    n_res   = w_res;
                    n_state = rc4_pkg::ST_P_HOLD;
                end
            end
            rc4_pkg::ST_P_HOLD: begin
                // hold the result until the output register frees up
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_res;
                    n_state     = rc4_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rc4_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rc4_pkg::ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_kidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_n         <= n_n;
            r_kidx      <= n_kidx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_fwd_i    <= n_fwd_i;
        r_fwd_j    <= n_fwd_j;
        r_data     <= n_data;
        r_res      <= n_res;
        r_out_byte <= n_out_byte;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_key_idx   = r_kidx;

endmodule

[sv/rc4_stream_cipher.sv]
`timescale 1ns / 1ps
// RC4 stream cipher, one byte per transaction: out_byte is data_byte XORed
// with the next keystream byte, so the same block encrypts and decrypts.
// The permutation lives in a 256 x 8 RAM with one write and one registered
// read port. For a plain byte, S[i] is read at the accepting edge. The
// remaining steps read S[j], write S[i] while reading S[S[i]+S[j]], and
// write S[j]. The next byte can be accepted the cycle after the result is
// loaded, so a plain byte is not taken until the one before is through.
// A transaction with start_message set first runs key scheduling from the
// configured key: an identity fill, then mixing with 4 RAM accesses per
// entry, before its own byte goes through the keystream step. A result
// that is not taken holds the sequencer and stalls the input. Every message
// must begin with a flagged transaction; write the key registers while idle.
// ----------------------------------------------------------------------------
// RC4 stream cipher top level
// Key register file, permutation RAM and sequencer core.
// ----------------------------------------------------------------------------
module rc4_stream_cipher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [rc4_pkg::DATA_W-1:0]      i_data_byte,
    input  logic                            i_start_message,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rc4_pkg::DATA_W-1:0]      o_out_byte,
    input  logic                            i_cfg_we,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    rc4_pkg::t_key_info                w_key;
    logic [rc4_pkg::KEY_IDX_W-1:0]     w_key_idx;
    logic                              w_ram_we;
    logic [rc4_pkg::S_ADDR_W-1:0]      w_ram_waddr;
    logic [rc4_pkg::DATA_W-1:0]        w_ram_wdata;
    logic [rc4_pkg::S_ADDR_W-1:0]      w_ram_raddr;
    logic [rc4_pkg::DATA_W-1:0]        w_ram_rdata;

    rc4_key_regs u_key_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_key_idx   (w_key_idx),
        .o_key       (w_key)
    );

    rc4_ram #(
        .WIDTH (rc4_pkg::DATA_W),
        .DEPTH (rc4_pkg::S_DEPTH)
    ) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    rc4_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_start_message (i_start_message),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_key_idx       (w_key_idx),
        .i_key           (w_key),
        .o_ram_we        (w_ram_we),
        .o_ram_waddr     (w_ram_waddr),
        .o_ram_wdata     (w_ram_wdata),
        .o_ram_raddr     (w_ram_raddr),
        .i_ram_rdata     (w_ram_rdata)
    );

endmodule
